// ===== hw/rtl/pcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

   // point tolerance in Q12.4 lsbs
   localparam logic [7:0] TOLERANCE = 8'd1;

   localparam int COORD_W  = 16;
   localparam int DIFF_W   = 17;
   localparam int PROD_W   = 34;
   localparam int DOT_W    = 35;
   localparam int ACROSS_W = 34;
   localparam int SQ_W     = 68;
   localparam int PART_W   = 32;
   localparam int LEN2_W   = 33;
   localparam int LIM_W    = 17;
   localparam int LIM2_W   = 33;
   localparam int BOUND_W  = 66;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // cycles for the segment terms to settle after a write
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_POINT = 3'd0,
      CSR_END_POINT   = 3'd1,
      CSR_BOUNDS_MIN  = 3'd2,
      CSR_BOUNDS_MAX  = 3'd3,
      CSR_MAX_OFFSET  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0]       start_x;
      logic [COORD_W-1:0]       start_y;
      logic [COORD_W-1:0]       end_x;
      logic [COORD_W-1:0]       end_y;
      logic [COORD_W-1:0]       min_x;
      logic [COORD_W-1:0]       min_y;
      logic [COORD_W-1:0]       max_x;
      logic [COORD_W-1:0]       max_y;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [LEN2_W-1:0]        len_sq;
      logic [BOUND_W-1:0]       bound_sq;
      logic                     busy;
   } seg_cfg_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] dot_a;
      logic signed [PROD_W-1:0] dot_b;
      logic signed [PROD_W-1:0] cross_a;
      logic signed [PROD_W-1:0] cross_b;
      logic                     in_box;
      logic                     near_start;
      logic                     near_end;
      logic                     first;
      logic                     last;
   } point_entry_type;

   function automatic logic near_eq(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      logic signed [DIFF_W-1:0] tol;
      d   = $signed({1'b0, a}) - $signed({1'b0, b});
      tol = $signed({{(DIFF_W-8){1'b0}}, TOLERANCE});
      return (d <= tol) && (d >= -tol);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pcc_req_if;
   logic                         valid;
   logic                         ready;
   logic [pcc_pkg::COORD_W-1:0]  point_x;
   logic [pcc_pkg::COORD_W-1:0]  point_y;
   logic                         is_last;

   modport source (output valid, output point_x, output point_y, output is_last, input ready);
   modport sink   (input valid, input point_x, input point_y, input is_last, output ready);
endinterface

interface pcc_rsp_if;
   logic valid;
   logic ready;
   logic line_valid;

   modport source (output valid, output line_valid, input ready);
   modport sink   (input valid, input line_valid, output ready);
endinterface

interface pcc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pcc_pkg::CSR_INDEX_W-1:0] index;
   logic [pcc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcc_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcc_csr (
   input  logic                 clock,
   input  logic                 reset,
   pcc_csr_if.sink              csr_bus,
   output pcc_pkg::seg_cfg_type seg_cfg
);

   logic [pcc_pkg::CSR_DATA_W-1:0] start_ff;
   logic [pcc_pkg::CSR_DATA_W-1:0] end_ff;
   logic [pcc_pkg::CSR_DATA_W-1:0] min_ff;
   logic [pcc_pkg::CSR_DATA_W-1:0] max_ff;
   logic [pcc_pkg::COORD_W-1:0]    max_offset_ff;
   logic [1:0]                     settle_ff;
   logic [1:0]                     settle_in;
   logic                           write;

   logic signed [pcc_pkg::DIFF_W-1:0] dx;
   logic signed [pcc_pkg::DIFF_W-1:0] dy;
   logic signed [pcc_pkg::PROD_W-1:0] dx_sq_full;
   logic signed [pcc_pkg::PROD_W-1:0] dy_sq_full;
   logic [pcc_pkg::LIM_W-1:0]         lim;
   logic [pcc_pkg::PROD_W-1:0]        lim_sq_full;
   logic [pcc_pkg::BOUND_W-1:0]       bound_sq_in;
   logic [pcc_pkg::PART_W-1:0]        dx_sq_ff;
   logic [pcc_pkg::PART_W-1:0]        dy_sq_ff;
   logic [pcc_pkg::LIM2_W-1:0]        lim_sq_ff;
   logic [pcc_pkg::LEN2_W-1:0]        len_sq_ff;
   logic [pcc_pkg::BOUND_W-1:0]       bound_sq_ff;

   assign csr_bus.ready = 1'b1;
   assign write = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         end_ff        <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         max_offset_ff <= '0;
      end else if (write) begin
         unique case (csr_bus.index)
            pcc_pkg::CSR_START_POINT: start_ff      <= csr_bus.data;
            pcc_pkg::CSR_END_POINT:   end_ff        <= csr_bus.data;
            pcc_pkg::CSR_BOUNDS_MIN:  min_ff        <= csr_bus.data;
            pcc_pkg::CSR_BOUNDS_MAX:  max_ff        <= csr_bus.data;
            pcc_pkg::CSR_MAX_OFFSET:  max_offset_ff <= csr_bus.data[pcc_pkg::COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (write) begin
         settle_in = pcc_pkg::SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= pcc_pkg::SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // segment terms: squares, then length, then the offset bound
   assign dx = $signed({1'b0, end_ff[31:16]}) - $signed({1'b0, start_ff[31:16]});
   assign dy = $signed({1'b0, end_ff[15:0]}) - $signed({1'b0, start_ff[15:0]});
   assign dx_sq_full  = dx * dx;
   assign dy_sq_full  = dy * dy;
   assign lim         = {1'b0, max_offset_ff} + {{(pcc_pkg::LIM_W-8){1'b0}}, pcc_pkg::TOLERANCE};
   assign lim_sq_full = lim * lim;
   assign bound_sq_in = lim_sq_ff * len_sq_ff;

   always_ff @(posedge clock) begin
      dx_sq_ff    <= dx_sq_full[pcc_pkg::PART_W-1:0];
      dy_sq_ff    <= dy_sq_full[pcc_pkg::PART_W-1:0];
      lim_sq_ff   <= lim_sq_full[pcc_pkg::LIM2_W-1:0];
      len_sq_ff   <= {1'b0, dx_sq_ff} + {1'b0, dy_sq_ff};
      bound_sq_ff <= bound_sq_in;
   end

   always_comb begin
      seg_cfg.start_x  = start_ff[31:16];
      seg_cfg.start_y  = start_ff[15:0];
      seg_cfg.end_x    = end_ff[31:16];
      seg_cfg.end_y    = end_ff[15:0];
      seg_cfg.min_x    = min_ff[31:16];
      seg_cfg.min_y    = min_ff[15:0];
      seg_cfg.max_x    = max_ff[31:16];
      seg_cfg.max_y    = max_ff[15:0];
      seg_cfg.dx       = dx;
      seg_cfg.dy       = dy;
      seg_cfg.len_sq   = len_sq_ff;
      seg_cfg.bound_sq = bound_sq_ff;
      seg_cfg.busy     = settle_ff != 2'd0;
   end

   a_write_holds_off: assert property (@(posedge clock) disable iff (reset)
      write |=> seg_cfg.busy)
      else $error("segment terms not marked busy after a register write");

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcc_front (
   input  logic                     clock,
   input  logic                     reset,
   pcc_req_if.sink                  req_bus,
   input  pcc_pkg::seg_cfg_type     seg_cfg,
   input  logic                     queue_full,
   output logic                     push,
   output pcc_pkg::point_entry_type entry
);

   logic first_ff;
   logic first_in;

   logic signed [pcc_pkg::DIFF_W-1:0] fx;
   logic signed [pcc_pkg::DIFF_W-1:0] fy;

   assign req_bus.ready = !queue_full && !seg_cfg.busy;
   assign push = req_bus.valid && req_bus.ready;

   // next point opens a new line once the last one went through
   assign first_in = push ? req_bus.is_last : first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   assign fx = $signed({1'b0, req_bus.point_x}) - $signed({1'b0, seg_cfg.start_x});
   assign fy = $signed({1'b0, req_bus.point_y}) - $signed({1'b0, seg_cfg.start_y});

   always_comb begin
      entry.dot_a      = fx * seg_cfg.dx;
      entry.dot_b      = fy * seg_cfg.dy;
      entry.cross_a    = fx * seg_cfg.dy;
      entry.cross_b    = fy * seg_cfg.dx;
      entry.in_box     = (req_bus.point_x >= seg_cfg.min_x) && (req_bus.point_x <= seg_cfg.max_x)
                      && (req_bus.point_y >= seg_cfg.min_y) && (req_bus.point_y <= seg_cfg.max_y);
      entry.near_start = pcc_pkg::near_eq(req_bus.point_x, seg_cfg.start_x)
                      && pcc_pkg::near_eq(req_bus.point_y, seg_cfg.start_y);
      entry.near_end   = pcc_pkg::near_eq(req_bus.point_x, seg_cfg.end_x)
                      && pcc_pkg::near_eq(req_bus.point_y, seg_cfg.end_y);
      entry.first      = first_ff;
      entry.last       = req_bus.is_last;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pcc_pkg::point_entry_type push_entry,
   input  logic                     pop,
   output pcc_pkg::point_entry_type head,
   output logic                     not_empty,
   output logic                     full
);

   pcc_pkg::point_entry_type slot_ff [pcc_pkg::QUEUE_DEPTH];

   logic [pcc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [pcc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [pcc_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic [pcc_pkg::QUEUE_CNT_W-1:0] count_in;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == pcc_pkg::QUEUE_CNT_W'(pcc_pkg::QUEUE_DEPTH);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcc_pkg::QUEUE_CNT_W'(pcc_pkg::QUEUE_DEPTH))
      else $error("point queue holds more entries than it has slots");

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pcc_pkg::seg_cfg_type     seg_cfg,
   input  pcc_pkg::point_entry_type head,
   input  logic                     not_empty,
   output logic                     pop,
   pcc_rsp_if.source                rsp_bus
);

   typedef struct packed {
      logic [pcc_pkg::ACROSS_W-1:0] across;
      logic                         ok;
      logic                         end_fail;
      logic                         last;
   } stage1_type;

   typedef struct packed {
      logic [pcc_pkg::SQ_W-1:0] across_sq;
      logic                     ok;
      logic                     end_fail;
      logic                     last;
   } stage2_type;

   logic adv;

   logic signed [pcc_pkg::DOT_W-1:0] dot;
   logic signed [pcc_pkg::DOT_W-1:0] cross_val;
   logic signed [pcc_pkg::DOT_W-1:0] neg_cross;
   logic signed [pcc_pkg::DOT_W-1:0] prev;
   logic signed [pcc_pkg::DOT_W-1:0] prev_ff;

   stage1_type s1_in;
   stage1_type s1_ff;
   logic       s1_valid_ff;
   stage2_type s2_in;
   stage2_type s2_ff;
   logic       s2_valid_ff;

   logic point_ok;
   logic failed_ff;
   logic failed_in;
   logic line_valid_in;
   logic line_valid_ff;
   logic rsp_valid_ff;

   assign adv = !rsp_valid_ff || rsp_bus.ready;
   assign pop = adv && not_empty;

   // projection rise test is the only serial step: it reads the dot of the point before
   always_comb begin
      dot       = $signed({head.dot_a[pcc_pkg::PROD_W-1], head.dot_a})
                + $signed({head.dot_b[pcc_pkg::PROD_W-1], head.dot_b});
      cross_val = $signed({head.cross_a[pcc_pkg::PROD_W-1], head.cross_a})
                - $signed({head.cross_b[pcc_pkg::PROD_W-1], head.cross_b});
      neg_cross = -cross_val;
      prev      = head.first ? -$signed({2'b00, seg_cfg.len_sq}) : prev_ff;

      s1_in.across   = cross_val[pcc_pkg::DOT_W-1] ? neg_cross[pcc_pkg::ACROSS_W-1:0]
                                                   : cross_val[pcc_pkg::ACROSS_W-1:0];
      s1_in.ok       = head.in_box && (dot > prev) && (seg_cfg.len_sq != '0)
                    && (!head.first || head.near_start);
      s1_in.end_fail = head.last && (head.first || !head.near_end);
      s1_in.last     = head.last;
   end

   always_comb begin
      s2_in.across_sq = s1_ff.across * s1_ff.across;
      s2_in.ok        = s1_ff.ok;
      s2_in.end_fail  = s1_ff.end_fail;
      s2_in.last      = s1_ff.last;
   end

   always_comb begin
      point_ok      = s2_ff.ok && (s2_ff.across_sq <= {2'b00, seg_cfg.bound_sq});
      line_valid_in = !(failed_ff || !point_ok || s2_ff.end_fail);
      failed_in     = failed_ff;
      if (s2_valid_ff) begin
         failed_in = s2_ff.last ? 1'b0 : (failed_ff || !point_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         failed_ff    <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= not_empty;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_ff.last;
         failed_ff    <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         line_valid_ff <= line_valid_in;
      end
      if (pop) begin
         prev_ff <= dot;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.line_valid = line_valid_ff;

   a_flag_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_valid_ff && s2_ff.last) |=> !failed_ff)
      else $error("fail flag carried past the end of a line");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_ff.last))
      else $error("result raised without a last point");

endmodule

`default_nettype wire

// ===== hw/rtl/polyline_corridor_checker.sv =====
// channel   | modport | handshake     | payload
// ----------+---------+---------------+-------------------------------------
// csr_bus   | sink    | valid / ready | index (3), data (32)
// req_bus   | sink    | valid / ready | point_x (16), point_y (16), is_last (1)
// rsp_bus   | source  | valid / ready | line_valid (1), one item per last point
//
// one point per cycle sustained while req ready is high; a result for a last point passes
// the queue slot, the two back stages and the result register before it shows
// reset and every csr write hold req ready low while the segment
// length and offset bound recompute
// a four entry queue between front and back absorbs stalls on the result side
`timescale 1ns / 1ps
`default_nettype none

module polyline_corridor_checker (
   input  logic       clock,
   input  logic       reset,
   pcc_csr_if.sink    csr_bus,
   pcc_req_if.sink    req_bus,
   pcc_rsp_if.source  rsp_bus
);

   pcc_pkg::seg_cfg_type     seg_cfg;
   pcc_pkg::point_entry_type push_entry;
   pcc_pkg::point_entry_type head;
   logic                     push;
   logic                     pop;
   logic                     not_empty;
   logic                     queue_full;

   pcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .seg_cfg (seg_cfg)
   );

   pcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .seg_cfg    (seg_cfg),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   pcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .full       (queue_full)
   );

   pcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .seg_cfg   (seg_cfg),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== tb/polyline_verdict_checker.sv =====
`timescale 1ns / 1ps

module polyline_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   pcc_csr_if          csr_bus,
   pcc_req_if          req_bus,
   pcc_rsp_if          rsp_bus,
   output int unsigned mismatches,
   output int unsigned verdicts_due,
   output int unsigned points_taken,
   output int unsigned lines_done,
   output int unsigned lines_accepted
);

   logic [pcc_pkg::CSR_DATA_W-1:0]   seg_start;
   logic [pcc_pkg::CSR_DATA_W-1:0]   seg_end;
   logic [pcc_pkg::CSR_DATA_W-1:0]   box_lo;
   logic [pcc_pkg::CSR_DATA_W-1:0]   box_hi;
   logic [pcc_pkg::COORD_W-1:0]      offset_max;
   logic                             line_open;
   logic                             line_bad;
   logic signed [pcc_pkg::DOT_W-1:0] last_progress;
   logic                             verdict_q[$];

   function automatic logic close_enough(input logic [pcc_pkg::COORD_W-1:0] a,
                                         input logic [pcc_pkg::COORD_W-1:0] b);
      logic signed [pcc_pkg::DIFF_W-1:0] gap;
      gap = $signed({1'b0, a}) - $signed({1'b0, b});
      if (gap < 0) begin
         gap = -gap;
      end
      return gap <= $signed({9'd0, pcc_pkg::TOLERANCE});
   endfunction

   function automatic void grade_point(input logic [pcc_pkg::COORD_W-1:0] px,
                                       input logic [pcc_pkg::COORD_W-1:0] py,
                                       input logic last,
                                       output logic emit,
                                       output logic verdict);
      logic [pcc_pkg::COORD_W-1:0]       sx, sy, ex, ey;
      logic signed [pcc_pkg::DIFF_W-1:0] dx, dy, fx, fy;
      logic signed [pcc_pkg::DOT_W-1:0]  len_sq, progress, cross_val, floor_dot;
      logic [pcc_pkg::ACROSS_W-1:0]      span;
      logic [pcc_pkg::LIM_W-1:0]         reach;
      logic [pcc_pkg::SQ_W-1:0]          span_sq, allowed_sq;
      logic                              ok;
      sx = seg_start[31:16];
      sy = seg_start[15:0];
      ex = seg_end[31:16];
      ey = seg_end[15:0];
      dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
      dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
      fx = $signed({1'b0, px}) - $signed({1'b0, sx});
      fy = $signed({1'b0, py}) - $signed({1'b0, sy});
      len_sq    = dx * dx + dy * dy;
      progress  = fx * dx + fy * dy;
      cross_val = fx * dy - fy * dx;
      // the first point of a line only has to beat minus the segment length squared
      floor_dot = line_open ? last_progress : -len_sq;
      span = pcc_pkg::ACROSS_W'(cross_val < 0 ? -cross_val : cross_val);
      reach = {1'b0, offset_max} + pcc_pkg::LIM_W'(pcc_pkg::TOLERANCE);
      span_sq = pcc_pkg::SQ_W'(span) * pcc_pkg::SQ_W'(span);
      allowed_sq = pcc_pkg::SQ_W'(reach) * pcc_pkg::SQ_W'(reach)
                 * pcc_pkg::SQ_W'(len_sq[pcc_pkg::LEN2_W-1:0]);
      ok = (len_sq != 0) && (progress > floor_dot) && (span_sq <= allowed_sq);
      if (!line_open && !(close_enough(px, sx) && close_enough(py, sy))) begin
         ok = 1'b0;
      end
      if (px < box_lo[31:16] || px > box_hi[31:16] ||
          py < box_lo[15:0] || py > box_hi[15:0]) begin
         ok = 1'b0;
      end
      if (!ok) begin
         line_bad = 1'b1;
      end
      emit    = last;
      verdict = 1'b0;
      if (!last) begin
         line_open     = 1'b1;
         last_progress = progress;
      end else begin
         if (!line_open || !(close_enough(px, ex) && close_enough(py, ey))) begin
            line_bad = 1'b1;
         end
         verdict       = !line_bad;
         line_open     = 1'b0;
         line_bad      = 1'b0;
         last_progress = -len_sq;
      end
   endfunction

   always @(posedge clock) begin : watch
      logic emit;
      logic verdict;
      logic want;
      if (reset) begin
         seg_start     = '0;
         seg_end       = '0;
         box_lo        = '0;
         box_hi        = '0;
         offset_max    = '0;
         line_open     = 1'b0;
         line_bad      = 1'b0;
         last_progress = '0;
         verdict_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (pcc_pkg::csr_index_type'(csr_bus.index))
               pcc_pkg::CSR_START_POINT: seg_start = csr_bus.data;
               pcc_pkg::CSR_END_POINT:   seg_end = csr_bus.data;
               pcc_pkg::CSR_BOUNDS_MIN:  box_lo = csr_bus.data;
               pcc_pkg::CSR_BOUNDS_MAX:  box_hi = csr_bus.data;
               pcc_pkg::CSR_MAX_OFFSET:  offset_max = csr_bus.data[pcc_pkg::COORD_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            points_taken++;
            grade_point(req_bus.point_x, req_bus.point_y, req_bus.is_last, emit, verdict);
            if (emit) begin
               verdict_q = {verdict_q, verdict};
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               $error("line_valid: expected no item, actual %0b", rsp_bus.line_valid);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               lines_done++;
               if (want) begin
                  lines_accepted++;
               end
               if (rsp_bus.line_valid !== want) begin
                  $error("line_valid: expected %0b, actual %0b", want, rsp_bus.line_valid);
                  mismatches++;
               end
            end
         end
      end
      verdicts_due = verdict_q.size();
   end

endmodule

// ===== tb/polyline_corridor_checker_tb.sv =====
`timescale 1ns / 1ps

module polyline_corridor_checker_tb;

   typedef enum int {
      LINE_CLEAN,
      LINE_NOISE,
      LINE_BROKEN
   } line_kind_type;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned DRAIN_CYCLES  = 10;
   localparam int unsigned RANDOM_POINTS = 900;
   localparam int unsigned PHASES        = 12;

   logic clock;
   logic reset;

   pcc_csr_if csr_bus();
   pcc_req_if req_bus();
   pcc_rsp_if rsp_bus();

   int unsigned mismatches;
   int unsigned verdicts_due;
   int unsigned points_taken;
   int unsigned lines_done;
   int unsigned lines_accepted;
   int unsigned cycle_count;

   // segment as last written, used to shape the lines
   int seg_sx, seg_sy, seg_ex, seg_ey, off_max;
   int unsigned sent_points;
   int unsigned settings_used;
   int unsigned burst_left;
   bit gaps_on   = 1'b1;
   bit stalls_on = 1'b1;

   polyline_corridor_checker dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   polyline_verdict_checker verdict_check (
      .clock          (clock),
      .reset          (reset),
      .csr_bus        (csr_bus),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatches     (mismatches),
      .verdicts_due   (verdicts_due),
      .points_taken   (points_taken),
      .lines_done     (lines_done),
      .lines_accepted (lines_accepted)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // result side: ready runs broken by short stalls while stalls_on is set
   initial begin : rsp_stall_pattern
      int unsigned run;
      rsp_bus.ready = 1'b0;
      forever begin
         run = $urandom_range(1, 12);
         repeat (run) @(negedge clock) rsp_bus.ready <= 1'b1;
         if (stalls_on) begin
            run = $urandom_range(1, 7);
            repeat (run) @(negedge clock) rsp_bus.ready <= 1'b0;
         end
      end
   end

   function automatic logic [pcc_pkg::COORD_W-1:0] to_coord(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > 65535) begin
         return 16'hFFFF;
      end
      return v[pcc_pkg::COORD_W-1:0];
   endfunction

   task automatic write_reg(input pcc_pkg::csr_index_type idx,
                            input logic [pcc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // drop valid and hold off until every line has its result
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (verdicts_due != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int sx, input int sy, input int ex, input int ey,
                            input logic [pcc_pkg::CSR_DATA_W-1:0] lo,
                            input logic [pcc_pkg::CSR_DATA_W-1:0] hi,
                            input int omax);
      wait_idle();
      write_reg(pcc_pkg::CSR_START_POINT, {to_coord(sx), to_coord(sy)});
      write_reg(pcc_pkg::CSR_END_POINT, {to_coord(ex), to_coord(ey)});
      write_reg(pcc_pkg::CSR_BOUNDS_MIN, lo);
      write_reg(pcc_pkg::CSR_BOUNDS_MAX, hi);
      write_reg(pcc_pkg::CSR_MAX_OFFSET, {16'd0, to_coord(omax)});
      seg_sx  = sx;
      seg_sy  = sy;
      seg_ex  = ex;
      seg_ey  = ey;
      off_max = omax;
      settings_used++;
   endtask

   task automatic send_point(input int x, input int y, input bit last);
      if (gaps_on && burst_left == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0) begin
         burst_left--;
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.point_x <= to_coord(x);
      req_bus.point_y <= to_coord(y);
      req_bus.is_last <= last;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sent_points++;
   endtask

   task automatic send_line(input line_kind_type kind);
      int count;
      int spoil;
      int x, y, wob;
      count = (kind == LINE_NOISE) ? int'($urandom_range(1, 4)) : int'($urandom_range(2, 9));
      spoil = int'($urandom_range(0, count - 1));
      wob   = off_max / 2;
      for (int k = 0; k < count; k++) begin
         if (kind == LINE_NOISE) begin
            x = int'($urandom_range(0, 65535));
            y = int'($urandom_range(0, 65535));
         end else begin
            x = seg_sx + (seg_ex - seg_sx) * k / (count - 1);
            y = seg_sy + (seg_ey - seg_sy) * k / (count - 1);
            if (k == 0 || k == count - 1) begin
               x += int'($urandom_range(0, 2)) - 1;
               y += int'($urandom_range(0, 2)) - 1;
            end else begin
               x += int'($urandom_range(0, 2 * wob)) - wob;
               y += int'($urandom_range(0, 2 * wob)) - wob;
            end
            if (kind == LINE_BROKEN && k == spoil) begin
               case ($urandom_range(0, 3))
                  0: x += int'($urandom_range(0, 4096)) - 2048;
                  1: begin
                     x = seg_sx;
                     y = seg_sy;
                  end
                  2: begin
                     x = int'($urandom_range(0, 65535));
                     y = int'($urandom_range(0, 65535));
                  end
                  default: x += 2;
               endcase
            end
         end
         send_point(x, y, k == count - 1);
      end
   endtask

   task automatic random_setting(input bit extreme);
      int sx, sy, ex, ey, omax, margin;
      if (extreme) begin
         sx   = $urandom_range(0, 1) ? 65535 : 0;
         sy   = $urandom_range(0, 1) ? 65535 : 0;
         ex   = $urandom_range(0, 1) ? 65535 : 0;
         ey   = $urandom_range(0, 1) ? 65535 : 0;
         omax = $urandom_range(0, 1) ? 65535 : 0;
      end else begin
         sx   = int'($urandom_range(0, 65535));
         sy   = int'($urandom_range(0, 65535));
         ex   = int'($urandom_range(0, 65535));
         ey   = int'($urandom_range(0, 65535));
         omax = int'($urandom_range(0, 1500));
      end
      margin = omax + int'($urandom_range(0, 40));
      configure(sx, sy, ex, ey,
                {to_coord((sx < ex ? sx : ex) - margin), to_coord((sy < ey ? sy : ey) - margin)},
                {to_coord((sx > ex ? sx : ex) + margin), to_coord((sy > ey ? sy : ey) + margin)},
                omax);
   endtask

   initial begin : stimulus
      int unsigned target;
      int unsigned pick;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.is_last = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = pcc_pkg::CSR_START_POINT;
      csr_bus.data    = '0;
      sent_points     = 0;
      settings_used   = 0;
      burst_left      = 0;
      seg_sx          = 0;
      seg_sy          = 0;
      seg_ex          = 0;
      seg_ey          = 0;
      off_max         = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset give a zero-length segment, so the line fails
      send_point(0, 0, 1'b0);
      send_point(0, 0, 1'b1);

      // full-range diagonal with the widest corridor
      configure(0, 0, 'hFFFF, 'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 'hFFFF);
      send_point(0, 0, 1'b0);
      send_point('hFFFF, 'hFFFF, 1'b1);
      send_point(0, 0, 1'b0);
      send_point('hFFFF, 0, 1'b0);
      send_point('hFFFF, 'hFFFF, 1'b1);
      // single point that is also the last one
      send_point(0, 0, 1'b1);

      // reversed diagonal, no offset allowed beyond tolerance
      configure('hFFFF, 'hFFFF, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 0);
      send_point('hFFFF, 'hFFFF, 1'b0);
      send_point('h8000, 'h8000, 1'b0);
      send_point(0, 0, 1'b1);
      // ends just within tolerance, then just outside it
      send_point('hFFFE, 'hFFFF, 1'b0);
      send_point(1, 0, 1'b1);
      send_point('hFFFD, 'hFFFF, 1'b0);
      send_point(0, 0, 1'b1);
      // projection that stalls instead of rising
      send_point('hFFFF, 'hFFFF, 1'b0);
      send_point('hFFFF, 'hFFFF, 1'b0);
      send_point(0, 0, 1'b1);
      // middle point off the corridor
      send_point('hFFFF, 'hFFFF, 1'b0);
      send_point('h8000, 'h7FF0, 1'b0);
      send_point(0, 0, 1'b1);

      // inverted box holds nothing
      configure('h100, 'h100, 'h200, 'h200, 32'hFFFF_FFFF, 32'h0000_0000, 'h40);
      send_point('h100, 'h100, 1'b0);
      send_point('h200, 'h200, 1'b1);

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         random_setting(phase % 4 == 3);
         gaps_on   = (phase % 3 != 0);
         stalls_on = (phase % 5 != 1);
         target    = sent_points + RANDOM_POINTS / PHASES;
         while (sent_points < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               send_line(LINE_CLEAN);
            end else if (pick == 7) begin
               send_line(LINE_NOISE);
            end else begin
               send_line(LINE_BROKEN);
            end
            if (sent_points + RANDOM_POINTS / (2 * PHASES) == target) begin
               wait_idle();
            end
         end
      end

      wait_idle();
      $display("covered %0d points in %0d lines over %0d register settings",
               points_taken, lines_done, settings_used);
      $display("%0d lines judged valid, %0d rejected", lines_accepted,
               lines_done - lines_accepted);
      if (mismatches == 0 && verdicts_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
